// File: rtl/stc_pkg.sv
// Package for the sorted table with cursor: transfer structs, opcodes and status codes.
// It depends on nothing else. The cell and the top level import it.
package stc_pkg;

  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIRST  = 2'd2;
  localparam logic [1:0] OP_NEXT   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_NO_NEXT = 3'd5;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
  } out_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert accepted and legal
    logic rem;  // remove accepted and key present
  } cell_cmd_t;

endpackage

// File: rtl/sorted_table_with_cursor.sv
// Top level of the sorted table with cursor: a chain of stc_cell instances plus
// cursor, result selection and the output register. Depends on stc_pkg and stc_cell.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one command per transfer:
//   insert, remove, go to first or go to next. Output channel out_valid /
//   out_stall / out_data returns exactly one result per command, in order.
//   The result of an accepted command is registered and presented in the next
//   cycle. Throughput is one command per cycle unless the receiver stalls; every
//   cell compares its key with the command key in parallel and the cells from the
//   affected place on shift one place in the same cycle; the chain sets the pace.
//   When the receiver stalls, the result is held in the output register and
//   in_stall rises, so no new command is taken until the result moves on.
//   Reset (rst, synchronous) empties the table, parks the cursor on cell 0
//   and drops any pending result. No clearing pass is needed: stale cells
//   carry a cleared valid bit and are never read.
module sorted_table_with_cursor #(
  parameter int CAPACITY     = 16,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  stc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output stc_pkg::out_t out_data
);
  import stc_pkg::*;

  // Stored widths: fields are masked to the parameter, never wider than the port.
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PW = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;

  logic [KW-1:0] k;
  logic [PW-1:0] p;

  logic [KW-1:0] cell_key [CAPACITY];
  logic [PW-1:0] cell_payload [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec;
  logic [CAPACITY+1:0] valid_ext;
  logic [CAPACITY:0]   eq_ext;

  // Cursor kept as one bit per cell.
  logic [CAPACITY-1:0] cur, cur_next;
  logic [CAPACITY-1:0] pos_vec, next_sel, rem_cur, first_vec, pick_vec;

  logic       accept;
  logic       any_eq, full, has_next, ins_ok, rem_ok, first_ok;
  logic [KW-1:0] pick_key;
  logic [PW-1:0] pick_payload;
  cell_cmd_t  cmd;
  out_t       result;

  assign k = in_data.key[KW-1:0];
  assign p = in_data.payload[PW-1:0];

  // Hold input while a result waits on a stalled receiver.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- cell chain
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KW-1:0] lk, rk;
    logic [PW-1:0] lp, rp;
    logic          lv, llt, rv;

    if (j == 0) begin : g_first
      assign lk  = '0;
      assign lp  = '0;
      assign lv  = 1'b0;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lk  = cell_key[j-1];
      assign lp  = cell_payload[j-1];
      assign lv  = valid_vec[j-1];
      assign llt = lt_vec[j-1];
    end

    if (j == CAPACITY-1) begin : g_last
      assign rk = '0;
      assign rp = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = cell_key[j+1];
      assign rp = cell_payload[j+1];
      assign rv = valid_vec[j+1];
    end

    stc_cell #(
      .KW(KW),
      .PW(PW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .new_key      (k),
      .new_payload  (p),
      .left_key     (lk),
      .left_payload (lp),
      .left_valid   (lv),
      .left_lt      (llt),
      .right_key    (rk),
      .right_payload(rp),
      .right_valid  (rv),
      .key          (cell_key[j]),
      .payload      (cell_payload[j]),
      .valid        (valid_vec[j]),
      .lt           (lt_vec[j]),
      .eq           (eq_vec[j])
    );
  end

  assign valid_ext = {2'b00, valid_vec};
  assign eq_ext    = {1'b0, eq_vec};

  // ------------------------------------------------------------ global flags
  assign any_eq   = |eq_vec;
  assign full     = valid_vec[CAPACITY-1];
  assign has_next = |next_sel;
  assign ins_ok   = (in_data.opcode == OP_INSERT) && !any_eq && !full;
  assign rem_ok   = (in_data.opcode == OP_REMOVE) && any_eq;
  assign first_ok = (in_data.opcode == OP_FIRST) && valid_vec[0];

  assign cmd.ins = accept && ins_ok;
  assign cmd.rem = accept && rem_ok;

  // Insert position, next step and post-remove cursor, cell by cell.
  always_comb begin
    first_vec    = '0;
    first_vec[0] = 1'b1;
    for (int j = 0; j < CAPACITY; j++) begin
      pos_vec[j]  = !lt_vec[j] && ((j == 0) ? 1'b1 : lt_vec[(j == 0) ? 0 : j-1]);
      next_sel[j] = (j != 0) && cur[(j == 0) ? 0 : j-1] && valid_vec[j];
      // Successor slides into the removed cell; else fall back to predecessor.
      rem_cur[j]  = (eq_vec[j] && valid_ext[j+1])
                  || (eq_ext[j+1] && !valid_ext[j+2])
                  || ((j == 0) && eq_vec[0] && !valid_ext[1]);
    end
  end

  always_comb begin
    case (in_data.opcode)
      OP_REMOVE: pick_vec = eq_vec;
      OP_FIRST:  pick_vec = first_vec;
      OP_NEXT:   pick_vec = next_sel;
      default:   pick_vec = '0;
    endcase
  end

  // One-hot read of the selected cell.
  always_comb begin
    pick_key     = '0;
    pick_payload = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      pick_key     = pick_key | ({KW{pick_vec[j]}} & cell_key[j]);
      pick_payload = pick_payload | ({PW{pick_vec[j]}} & cell_payload[j]);
    end
  end

  // ------------------------------------------------------------------ result
  always_comb begin
    result = '0;
    case (in_data.opcode)
      OP_INSERT: begin
        if (any_eq) begin
          result.status = ST_DUP;
        end else if (full) begin
          result.status = ST_FULL;
        end else begin
          result.status  = ST_OK;
          result.out_key = KEY_W'(k);
        end
      end
      OP_REMOVE: begin
        if (any_eq) begin
          result.status      = ST_OK;
          result.out_key     = KEY_W'(k);
          result.out_payload = PAYLOAD_W'(pick_payload);
        end else begin
          result.status = ST_ABSENT;
        end
      end
      OP_FIRST: begin
        if (valid_vec[0]) begin
          result.status      = ST_OK;
          result.out_key     = KEY_W'(pick_key);
          result.out_payload = PAYLOAD_W'(pick_payload);
        end else begin
          result.status = ST_EMPTY;
        end
      end
      OP_NEXT: begin
        if (has_next) begin
          result.status      = ST_OK;
          result.out_key     = KEY_W'(pick_key);
          result.out_payload = PAYLOAD_W'(pick_payload);
        end else begin
          result.status = ST_NO_NEXT;
        end
      end
      default: result = '0;
    endcase
  end

  // ------------------------------------------------------------------ cursor
  always_comb begin
    cur_next = cur;
    if (ins_ok) begin
      cur_next = pos_vec;
    end else if (rem_ok) begin
      cur_next = rem_cur;
    end else if (first_ok) begin
      cur_next = first_vec;
    end else if ((in_data.opcode == OP_NEXT) && has_next) begin
      cur_next = next_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= CAPACITY'(1);
    end else if (accept) begin
      cur <= cur_next;
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/stc_cell.sv
// One cell of the sorted table chain: holds a key, a payload and a valid bit.
// Depends on stc_pkg for the command struct; neighbors feed it shift data.
module stc_cell #(
  parameter int KW = 16,
  parameter int PW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  stc_pkg::cell_cmd_t cmd,
  input  logic [KW-1:0]     new_key,
  input  logic [PW-1:0]     new_payload,
  input  logic [KW-1:0]     left_key,
  input  logic [PW-1:0]     left_payload,
  input  logic              left_valid,
  input  logic              left_lt,
  input  logic [KW-1:0]     right_key,
  input  logic [PW-1:0]     right_payload,
  input  logic              right_valid,
  output logic [KW-1:0]     key,
  output logic [PW-1:0]     payload,
  output logic              valid,
  output logic              lt,
  output logic              eq
);
  import stc_pkg::*;

  logic at_pos;

  assign lt     = valid && (key < new_key);
  assign eq     = valid && (key == new_key);
  assign at_pos = left_lt && !lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins && !lt) begin
      valid <= at_pos ? 1'b1 : left_valid;
    end else if (cmd.rem && !lt) begin
      valid <= right_valid;
    end
  end

  // Payload side: take the new entry, shift right on insert, shift left on remove.
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      key     <= at_pos ? new_key : left_key;
      payload <= at_pos ? new_payload : left_payload;
    end else if (cmd.rem && !lt) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

endmodule
